FILE: rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg - C-style byte escaper shared definitions
// Character codes, register indexes, the escape record that moves from the
// classifier to the emitter, and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PASS_HIGH   = 4'd0,
    REG_QUOTE_MATCH = 4'd1
  } cse_reg_t;

  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7e;
  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam logic [7:0] DIGIT_9   = 8'h39;
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_F   = 8'h66;
  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_F   = 8'h46;
  localparam logic [7:0] ALPHA_OFS = 8'h57;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } cse_op_t;

  typedef struct packed {
    logic    valid;
    cse_op_t op;
  } cse_push_t;

  function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (DIGIT_0 + wide) : (ALPHA_OFS + wide);
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] c);
    return (c >= DIGIT_0 && c <= DIGIT_9) || (c >= LOWER_A && c <= LOWER_F) ||
           (c >= UPPER_A && c <= UPPER_F);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cse_ifs.sv
// ----------------------------------------------------------------------------
// cse_ifs - C-style byte escaper channel interfaces
// Source bytes in, escaped bytes out, and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       end_of_string;

  modport source (output valid, output src_byte, output end_of_string, input ready);
  modport sink   (input valid, input src_byte, input end_of_string, output ready);
endinterface

interface cse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface cse_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cse_pkg::CFG_IDX_W-1:0]  index;
  logic [cse_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/cse_front.sv
// ----------------------------------------------------------------------------
// cse_front - classifier
// Holds the registers and the hex flag, accepts source bytes and turns each
// into an escape record of one to four bytes for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_front (
  input  logic              clk,
  input  logic              rst_n,
  cse_in_if.sink            in_ch,
  cse_cfg_if.sink           cfg_ch,
  output cse_pkg::cse_push_t push,
  input  logic              push_ready,
  output logic              hex_flag
);
  import cse_pkg::*;

  logic       pass_high_r;
  logic [7:0] quote_match_r;
  logic       prev_was_hex_r;
  logic       prev_was_hex_nxt;
  logic [7:0] c;
  logic       quote_hit;
  logic       printable;
  logic       hex_now;
  logic       accept;
  cse_op_t    op;

  assign c         = in_ch.src_byte;
  assign quote_hit = (quote_match_r == 8'h00) || (c == quote_match_r);
  assign printable = (c >= PRINT_LO) && (c <= PRINT_HI);
  assign accept    = in_ch.valid && push_ready;

  always_comb begin
    op       = '0;
    hex_now  = 1'b0;
    unique case (c)
      CH_NL: begin
        op.bytes[0] = CH_BSLASH; op.bytes[1] = CH_N;      op.last_idx = 2'd1;
      end
      CH_CR: begin
        op.bytes[0] = CH_BSLASH; op.bytes[1] = CH_R;      op.last_idx = 2'd1;
      end
      CH_TAB: begin
        op.bytes[0] = CH_BSLASH; op.bytes[1] = CH_T;      op.last_idx = 2'd1;
      end
      CH_BSLASH: begin
        op.bytes[0] = CH_BSLASH; op.bytes[1] = CH_BSLASH; op.last_idx = 2'd1;
      end
      CH_DQUOTE, CH_SQUOTE, CH_BTICK: begin
        if (quote_hit) begin
          op.bytes[0] = CH_BSLASH; op.bytes[1] = c; op.last_idx = 2'd1;
        end else begin
          op.bytes[0] = c; op.last_idx = 2'd0;
        end
      end
      default: begin
        if ((!pass_high_r || !c[7]) &&
            (!printable || (prev_was_hex_r && is_hex_digit(c)))) begin
          op.bytes[0] = CH_BSLASH;
          op.bytes[1] = CH_X;
          op.bytes[2] = nib_to_ascii(c[7:4]);
          op.bytes[3] = nib_to_ascii(c[3:0]);
          op.last_idx = 2'd3;
          hex_now     = 1'b1;
        end else begin
          op.bytes[0] = c;
          op.last_idx = 2'd0;
        end
      end
    endcase
  end

  assign prev_was_hex_nxt = accept ? (hex_now && !in_ch.end_of_string) : prev_was_hex_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_high_r    <= 1'b1;
      quote_match_r  <= 8'h00;
      prev_was_hex_r <= 1'b0;
    end else begin
      prev_was_hex_r <= prev_was_hex_nxt;
      if (cfg_ch.valid) begin
        priority if (cfg_ch.index == REG_PASS_HIGH) begin
          pass_high_r <= cfg_ch.data[0];
        end else if (cfg_ch.index == REG_QUOTE_MATCH) begin
          quote_match_r <= cfg_ch.data;
        end else begin
          pass_high_r <= pass_high_r;
        end
      end
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign push.valid   = in_ch.valid;
  assign push.op      = op;
  assign hex_flag     = prev_was_hex_r;

endmodule

`default_nettype wire

FILE: rtl/cse_queue.sv
// ----------------------------------------------------------------------------
// cse_queue - escape record queue
// Small register FIFO between classifier and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_queue #(
  parameter int unsigned DEPTH = cse_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cse_pkg::cse_push_t push,
  output logic               push_ready,
  output logic               pop_valid,
  output cse_pkg::cse_op_t   pop_op,
  input  logic               pop_ready
);
  import cse_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cse_op_t          entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_op     = entries_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push.op;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cse_back.sv
// ----------------------------------------------------------------------------
// cse_back - emitter
// Takes escape records from the queue and sends their bytes one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  cse_pkg::cse_op_t pop_op,
  output logic             pop_ready,
  cse_out_if.source        out_ch
);
  import cse_pkg::*;

  cse_op_t    cur_r;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       busy_r;
  logic       busy_nxt;
  logic       at_last;
  logic       xfer;

  assign at_last   = (idx_r == cur_r.last_idx);
  assign xfer      = busy_r && out_ch.ready;
  assign pop_ready = !busy_r || (xfer && at_last);

  always_comb begin
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (pop_valid && pop_ready) begin
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (xfer && at_last) begin
      busy_nxt = 1'b0;
    end else if (xfer) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_r <= pop_op;
    end
  end

  assign out_ch.valid       = busy_r;
  assign out_ch.out_byte    = cur_r.bytes[idx_r];
  assign out_ch.last_of_run = at_last;

endmodule

`default_nettype wire

FILE: rtl/c_style_byte_escaper.sv
// ----------------------------------------------------------------------------
// c_style_byte_escaper - C-style byte escaper, top level
//
//   channel  | dir | payload                          | transfer
//   ---------+-----+----------------------------------+---------------------
//   in_ch    | in  | src_byte[7:0], end_of_string     | valid & ready
//   out_ch   | out | out_byte[7:0], last_of_run       | valid & ready
//   cfg_ch   | in  | index[3:0], data[7:0]            | valid & ready (ready=1)
//
// Each source byte is classified in the cycle it is taken and becomes one to
// four output bytes, four for a hex escape; the output channel moves one byte
// per cycle while out_ch.ready is high and a record is waiting.
// Up to QUEUE_DEPTH escape records sit between classifier and emitter, so
// input keeps flowing while the output stalls until the queue is full.
// Reset (rst_n low, synchronous) empties the queue, clears the hex flag,
// turns high-byte pass-through on and loads quote_match = 0.
// ----------------------------------------------------------------------------
`default_nettype none

module c_style_byte_escaper #(
  parameter int unsigned QUEUE_DEPTH = cse_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  cse_in_if.sink    in_ch,
  cse_out_if.source out_ch,
  cse_cfg_if.sink   cfg_ch
);
  import cse_pkg::*;

  cse_push_t push;
  logic      push_ready;
  logic      pop_valid;
  cse_op_t   pop_op;
  logic      pop_ready;
  logic      hex_flag;

  cse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push       (push),
    .push_ready (push_ready),
    .hex_flag   (hex_flag)
  );

  cse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop_ready  (pop_ready)
  );

  cse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_op    (pop_op),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_eos_clears_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.end_of_string) |=> !hex_flag)
    else $error("hex flag survived end of string");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> pop_valid)
    else $error("input stalled with empty queue");

  a_lead_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last_of_run) |->
      (out_ch.out_byte == CH_BSLASH || out_ch.out_byte == CH_X ||
       (out_ch.out_byte >= DIGIT_0 && out_ch.out_byte <= DIGIT_9) ||
       (out_ch.out_byte >= LOWER_A && out_ch.out_byte <= LOWER_F)))
    else $error("unexpected leading escape byte");
`endif

endmodule

`default_nettype wire
